// File: src/linear_probe_hash_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear-probe hash table
// Shared checks, each clocked on the rising edge and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define LPHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LPHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Types, sizes and codes shared by the hash table controller and datapath.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int SLOTS         = 64;
    localparam int KEY_BITS      = 32;
    localparam int HASH_BITS     = 32;
    localparam int IDX_W         = $clog2(SLOTS);
    localparam int CNT_W         = IDX_W + 1;
    localparam int LIMIT_W       = 7;
    localparam int LIMIT_RESET   = 32;
    localparam int STATUS_W      = 3;

    typedef enum logic [1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_STEP   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_END       = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_LIVE  = 2'd1,
        TAG_DEAD  = 2'd2
    } t_tag;

    typedef struct packed {
        t_tag                 tag;
        logic [HASH_BITS-1:0] hash;
        logic [KEY_BITS-1:0]  key;
    } t_row;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture request, seed probe index
        logic rd;     // read slot at probe index
        logic chk;    // evaluate slot just read
        logic adv;    // move to next slot
        logic fin;    // commit table update and result
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_step;
        logic scan_end;
        logic stop;
        logic last;
        logic out_free;
    } t_dp_stat;

    localparam int REG_LOAD_LIMIT = 0;

endpackage

// File: src/lpht_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer for one command: read a slot, check it, advance, then commit.
// ----------------------------------------------------------------------------
module lpht_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  lpht_pkg::t_dp_stat i_stat,
    output lpht_pkg::t_ctl_cmd o_cmd
);
    import lpht_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                // step that starts past the last slot has nothing to scan
                if (i_stat.is_step && i_stat.scan_end) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.chk = 1'b1;
                if (i_stat.stop || i_stat.last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = S_READ;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: src/lpht_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_dp
// Slot store, probe index and counters, free-slot tracking and result register.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_macros.svh"

module lpht_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpht_pkg::t_ctl_cmd            i_cmd,
    output lpht_pkg::t_dp_stat            o_stat,
    input  logic [1:0]                    i_op,
    input  logic [lpht_pkg::KEY_BITS-1:0] i_key,
    input  logic [lpht_pkg::HASH_BITS-1:0] i_key_hash,
    input  logic [lpht_pkg::IDX_W-1:0]    i_start_slot,
    input  logic                          i_from_start,
    input  logic [lpht_pkg::LIMIT_W-1:0]  i_load_limit,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [lpht_pkg::STATUS_W-1:0] o_status,
    output logic [lpht_pkg::IDX_W-1:0]    o_slot,
    output logic [lpht_pkg::KEY_BITS-1:0] o_key_out,
    output logic [lpht_pkg::CNT_W-1:0]    o_live_count
);
    import lpht_pkg::*;

    // request
    t_cmd                 r_op;
    logic [KEY_BITS-1:0]  r_key;
    logic [HASH_BITS-1:0] r_hash;

    // probe state
    logic [IDX_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_cnt;
    logic [IDX_W-1:0]     r_free;
    logic                 r_free_vld;
    logic                 r_hit;

    // slot store
    t_row                 mem [SLOTS];
    t_row                 r_rd;
    logic                 r_rd_vld;
    logic [SLOTS-1:0]     r_vld;
    logic [CNT_W-1:0]     r_entry_count;

    // result register
    logic                 r_o_valid;
    t_status              r_o_status;
    logic [IDX_W-1:0]     r_o_slot;
    logic [KEY_BITS-1:0]  r_o_key;
    logic [CNT_W-1:0]     r_o_count;

    t_tag                 rd_tag;
    logic                 is_step;
    logic                 slot_live;
    logic                 slot_empty;
    logic                 slot_hit;
    logic [CNT_W-1:0]     seed;
    logic                 limit_ok;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    t_row                 wr_row;
    logic                 n_set_vld;
    logic [CNT_W-1:0]     n_entry_count;
    t_status              n_status;
    logic [IDX_W-1:0]     n_slot;
    logic [KEY_BITS-1:0]  n_key_out;

    assign is_step    = (r_op == CMD_STEP);
    assign rd_tag     = r_rd_vld ? r_rd.tag : TAG_EMPTY;
    assign slot_live  = (rd_tag == TAG_LIVE);
    assign slot_empty = (rd_tag == TAG_EMPTY);
    assign slot_hit   = is_step ? slot_live
                                : (slot_live && r_rd.hash == r_hash && r_rd.key == r_key);
    assign seed       = i_from_start ? '0 : ({1'b0, i_start_slot} + CNT_W'(1));
    assign limit_ok   = ({1'b0, r_entry_count} + {{CNT_W{1'b0}}, 1'b1})
                        <= {{(CNT_W + 1 - LIMIT_W){1'b0}}, i_load_limit};

    assign o_stat.is_step  = is_step;
    assign o_stat.scan_end = (r_cnt == CNT_W'(SLOTS));
    assign o_stat.stop     = slot_hit || (!is_step && slot_empty);
    assign o_stat.last     = (r_cnt == CNT_W'(SLOTS - 1));
    assign o_stat.out_free = !r_o_valid || i_m_tready;

    // outcome of the command, used only on the commit cycle
    always_comb begin
        wr_en         = 1'b0;
        wr_addr       = r_idx;
        wr_row        = r_rd;
        n_set_vld     = 1'b0;
        n_entry_count = r_entry_count;
        n_status      = ST_NOT_FOUND;
        n_slot        = '0;
        n_key_out     = '0;
        if (is_step) begin
            if (r_hit) begin
                n_status  = ST_FOUND;
                n_slot    = r_idx;
                n_key_out = r_rd.key;
            end else begin
                n_status  = ST_END;
            end
        end else if (r_hit) begin
            n_status  = ST_FOUND;
            n_slot    = r_idx;
            n_key_out = r_rd.key;
            if (r_op == CMD_REMOVE) begin
                // leave a tombstone, keep hash and key as they were
                wr_en      = 1'b1;
                wr_row.tag = TAG_DEAD;
                if (r_entry_count != '0) begin
                    n_entry_count = r_entry_count - CNT_W'(1);
                end
            end
        end else if (r_op == CMD_INSERT) begin
            if (!r_free_vld || !limit_ok) begin
                n_status = ST_FULL;
            end else begin
                wr_en         = 1'b1;
                wr_addr       = r_free;
                wr_row.tag    = TAG_LIVE;
                wr_row.hash   = r_hash;
                wr_row.key    = r_key;
                n_set_vld     = 1'b1;
                n_entry_count = r_entry_count + CNT_W'(1);
                n_status      = ST_INSERTED;
                n_slot        = r_free;
                n_key_out     = r_key;
            end
        end
    end

    // request capture and probe walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= t_cmd'(i_op);
            r_key      <= i_key;
            r_hash     <= i_key_hash;
            r_free_vld <= 1'b0;
            r_hit      <= 1'b0;
            if (t_cmd'(i_op) == CMD_STEP) begin
                r_idx <= seed[IDX_W-1:0];
                r_cnt <= seed;
            end else begin
                r_idx <= i_key_hash[IDX_W-1:0];
                r_cnt <= '0;
            end
        end else begin
            if (i_cmd.chk) begin
                r_hit <= slot_hit;
                // remember the first slot an insert could take
                if (!r_free_vld && !slot_live) begin
                    r_free     <= r_idx;
                    r_free_vld <= 1'b1;
                end
            end
            if (i_cmd.adv) begin
                r_idx <= r_idx + IDX_W'(1);
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // slot store: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin && wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        if (i_cmd.rd) begin
            r_rd     <= mem[r_idx];
            r_rd_vld <= r_vld[r_idx];
        end
    end

    // written-slot flags and live count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            r_entry_count <= '0;
        end else if (i_cmd.fin) begin
            r_entry_count <= n_entry_count;
            if (n_set_vld) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_o_status <= n_status;
            r_o_slot   <= n_slot;
            r_o_key    <= n_key_out;
            r_o_count  <= n_entry_count;
        end
    end

    assign o_m_tvalid   = r_o_valid;
    assign o_status     = r_o_status;
    assign o_slot       = r_o_slot;
    assign o_key_out    = r_o_key;
    assign o_live_count = r_o_count;

    `LPHT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_entry_count <= CNT_W'(SLOTS), "live count above slot count")
    `LPHT_ASSERT_NOW(a_fin_out_free, i_clk, i_rst_n, i_cmd.fin, !r_o_valid || i_m_tready, "commit while result register busy")
    `LPHT_ASSERT_NEXT(a_fin_valid, i_clk, i_rst_n, i_cmd.fin, r_o_valid, "commit did not raise result valid")
    `LPHT_ASSERT_NOW(a_adv_not_stop, i_clk, i_rst_n, i_cmd.adv, !o_stat.stop && !o_stat.last, "probe advanced past a stop")

endmodule

// File: src/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key table with linear probing, tombstones and a step scan.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                 | payload
//  s        | in  | i_s_tvalid / o_s_tready   | tuser: cmd; tdata: key, key_hash,
//           |     |                           |        start_slot, from_start
//  m        | out | o_m_tvalid / i_m_tready   | tuser: status; tdata: slot, key_out,
//           |     |                           |        live_count
//  apb      | in  | psel / penable / pready   | load_limit at address 0
//
//  The loop is one registered read of the slot store followed by one check of
//  that slot.
//  Reset: synchronous; the store needs no clearing pass, unwritten slots read
//  as empty through a flag per slot. load_limit resets to 32.
//  Stalls: one result waits in the output register while the next beat is
//  accepted; the commit of that next command waits until the result is taken.
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // [31:0] key, [63:32] key_hash,
                                     // [69:64] start_slot, [70] from_start
    input  logic [1:0]  i_s_tuser,   // [1:0] cmd
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [5:0] slot, [37:6] key_out, [44:38] live_count
    output logic [2:0]  o_m_tuser,   // [2:0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lpht_pkg::*;

    logic [LIMIT_W-1:0]  r_load_limit;
    t_ctl_cmd            ctl_cmd;
    t_dp_stat            dp_stat;
    logic [IDX_W-1:0]    m_slot;
    logic [KEY_BITS-1:0] m_key;
    logic [CNT_W-1:0]    m_count;
    logic                reg_sel;

    assign reg_sel = (paddr[2] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(32 - LIMIT_W){1'b0}}, r_load_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_limit <= LIMIT_W'(LIMIT_RESET);
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_load_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    lpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (dp_stat),
        .o_cmd      (ctl_cmd)
    );

    lpht_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (ctl_cmd),
        .o_stat       (dp_stat),
        .i_op         (i_s_tuser),
        .i_key        (i_s_tdata[31:0]),
        .i_key_hash   (i_s_tdata[63:32]),
        .i_start_slot (i_s_tdata[69:64]),
        .i_from_start (i_s_tdata[70]),
        .i_load_limit (r_load_limit),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_status     (o_m_tuser),
        .o_slot       (m_slot),
        .o_key_out    (m_key),
        .o_live_count (m_count)
    );

    assign o_m_tdata = {3'b000, m_count, m_key, m_slot};

endmodule

// File: sim/tb_linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Drives find, insert, remove and step commands into the hash table over
// several load limits, keeps a shadow table to predict every answer, and
// checks each result beat in order with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;
    localparam int POOL_SIZE      = 96;
    localparam int REG_SPARE      = 1;   // unmapped register index

    typedef struct packed {
        t_cmd                 cmd;
        logic [KEY_BITS-1:0]  key;
        logic [HASH_BITS-1:0] hash;
        logic [IDX_W-1:0]     start;
        logic                 from0;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [IDX_W-1:0]    slot;
        logic [KEY_BITS-1:0] key;
        logic [CNT_W-1:0]    live;
    } t_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [71:0] i_s_tdata  = '0;   // [31:0] key, [63:32] key_hash,
                                    // [69:64] start_slot, [70] from_start
    logic [1:0]  i_s_tuser  = '0;   // [1:0] cmd
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;         // [5:0] slot, [37:6] key_out, [44:38] live_count
    logic [2:0]  o_m_tuser;         // [2:0] status
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    linear_probe_hash_table uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // shadow of the slot store and its registers
    logic [KEY_BITS-1:0]  shadow_key  [SLOTS];
    logic [HASH_BITS-1:0] shadow_hash [SLOTS];
    t_tag                 shadow_tag  [SLOTS];
    int unsigned          shadow_live = 0;
    int unsigned          limit_val   = LIMIT_RESET;

    t_req    cmd_backlog  [$];
    t_result results_due  [$];
    logic [KEY_BITS-1:0]  pool_key  [POOL_SIZE];
    logic [HASH_BITS-1:0] pool_hash [POOL_SIZE];

    int  err_count    = 0;
    int  idle_cycles  = 0;
    int  send_gap     = 0;
    int  recv_gap     = 0;
    bit  quiet        = 1'b0;
    bit  s_took       = 1'b0;

    wire s_fire   = i_s_tvalid && o_s_tready;
    wire m_fire   = o_m_tvalid && i_m_tready;
    wire apb_fire = psel && penable && pready;

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            shadow_tag[s] = TAG_EMPTY;
        end
    end

    // Predict one command's answer and update the shadow table.
    function automatic t_result apply_table_cmd(t_req r);
        t_result res;
        int      idx;
        int      hit;
        int      free_at;
        bit      done;
        res.status = ST_NOT_FOUND;
        res.slot   = '0;
        res.key    = '0;
        done       = 1'b0;
        if (r.cmd == CMD_STEP) begin
            res.status = ST_END;
            idx = r.from0 ? 0 : int'(r.start) + 1;
            while (idx < SLOTS && !done) begin
                if (shadow_tag[idx] == TAG_LIVE) begin
                    res.status = ST_FOUND;
                    res.slot   = IDX_W'(idx);
                    res.key    = shadow_key[idx];
                    done       = 1'b1;
                end
                idx++;
            end
        end else begin
            hit     = -1;
            free_at = -1;
            idx     = int'(r.hash[IDX_W-1:0]);
            for (int n = 0; n < SLOTS && !done; n++) begin
                if (free_at < 0 && shadow_tag[idx] != TAG_LIVE)
                    free_at = idx;
                if (shadow_tag[idx] == TAG_EMPTY) begin
                    done = 1'b1;
                end else if (shadow_tag[idx] == TAG_LIVE && shadow_hash[idx] == r.hash
                             && shadow_key[idx] == r.key) begin
                    hit  = idx;
                    done = 1'b1;
                end else begin
                    idx = (idx + 1) % SLOTS;
                end
            end
            if (hit >= 0) begin
                res.status = ST_FOUND;
                res.slot   = IDX_W'(hit);
                res.key    = shadow_key[hit];
                if (r.cmd == CMD_REMOVE) begin
                    shadow_tag[hit] = TAG_DEAD;
                    if (shadow_live > 0)
                        shadow_live--;
                end
            end else if (r.cmd == CMD_INSERT) begin
                if (free_at < 0 || shadow_live + 1 > limit_val) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_key[free_at]  = r.key;
                    shadow_hash[free_at] = r.hash;
                    shadow_tag[free_at]  = TAG_LIVE;
                    shadow_live++;
                    res.status = ST_INSERTED;
                    res.slot   = IDX_W'(free_at);
                    res.key    = r.key;
                end
            end
        end
        res.live = CNT_W'(shadow_live);
        return res;
    endfunction

    task automatic flag_error(input string what);
        err_count++;
        if (err_count <= REPORT_LIMIT)
            $display("mismatch @%0t: %s", $realtime, what);
    endtask

    // Mostly short gaps, a few long ones, with occasional quiet stretches.
    function automatic int draw_gap();
        int r;
        if ($urandom_range(199) == 0)
            quiet = !quiet;
        if (quiet)
            return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // stream driver
    always @(negedge i_clk) begin : drive_beats
        t_req r;
        if (i_rst_n) begin
            if (!i_s_tvalid || s_took) begin
                if (send_gap != 0) begin
                    send_gap   <= send_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    r = cmd_backlog.pop_front();
                    i_s_tdata  <= {1'b0, r.from0, r.start, r.hash, r.key};
                    i_s_tuser  <= r.cmd;
                    i_s_tvalid <= 1'b1;
                    send_gap   <= draw_gap();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            if (recv_gap != 0) begin
                recv_gap   <= recv_gap - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                recv_gap   <= draw_gap();
            end
        end
    end

    // monitor: check result beats, predict accepted commands
    always @(posedge i_clk) begin : watch_beats
        t_req    r;
        t_result got;
        t_result want;
        s_took <= s_fire;
        if (i_rst_n && m_fire) begin
            got.status = t_status'(o_m_tuser);
            got.slot   = o_m_tdata[5:0];
            got.key    = o_m_tdata[37:6];
            got.live   = o_m_tdata[44:38];
            if (results_due.size() == 0) begin
                flag_error($sformatf("unexpected result status=%0d slot=%0d key=%h live=%0d",
                                     got.status, got.slot, got.key, got.live));
            end else begin
                want = results_due.pop_front();
                if (got.status !== want.status || got.slot !== want.slot
                    || got.key !== want.key || got.live !== want.live)
                    flag_error($sformatf({"exp status=%0d slot=%0d key=%h live=%0d, ",
                                          "got status=%0d slot=%0d key=%h live=%0d"},
                                         want.status, want.slot, want.key, want.live,
                                         got.status, got.slot, got.key, got.live));
            end
        end
        if (i_rst_n && s_fire) begin
            r.cmd   = t_cmd'(i_s_tuser);
            r.key   = i_s_tdata[31:0];
            r.hash  = i_s_tdata[63:32];
            r.start = i_s_tdata[69:64];
            r.from0 = i_s_tdata[70];
            results_due.push_back(apply_table_cmd(r));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || s_fire || m_fire || apb_fire) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_cmd(input t_cmd c, input logic [31:0] k, input logic [31:0] h,
                            input logic [5:0] st, input logic f0);
        t_req r;
        r.cmd   = c;
        r.key   = k;
        r.hash  = h;
        r.start = st;
        r.from0 = f0;
        cmd_backlog.push_back(r);
    endtask

    // Hold until every command is accepted and answered.
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || i_s_tvalid || results_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input int index, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(4 * index);
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (index == REG_LOAD_LIMIT)
            limit_val = data[LIMIT_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_check(input int index, input logic [31:0] want);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= 3'(4 * index);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata !== want)
            flag_error($sformatf("register read exp %h got %h", want, prdata));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Queue n random commands; keys mostly come from the first span pool entries.
    task automatic queue_random(input int n, input int w_ins, input int w_find,
                                input int w_rem, input int w_step, input int span);
        t_cmd c;
        int   r;
        int   p;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(w_ins + w_find + w_rem + w_step - 1);
            if (r < w_ins)                       c = CMD_INSERT;
            else if (r < w_ins + w_find)         c = CMD_FIND;
            else if (r < w_ins + w_find + w_rem) c = CMD_REMOVE;
            else                                 c = CMD_STEP;
            p = $urandom_range(span - 1);
            r = $urandom_range(99);
            if (c == CMD_STEP || r >= 95)
                push_cmd(c, $urandom, $urandom, 6'($urandom), 1'b0);
            else if (r >= 88)
                push_cmd(c, pool_key[p], $urandom, 6'($urandom), 1'($urandom));
            else
                push_cmd(c, pool_key[p], pool_hash[p], 6'($urandom), 1'($urandom));
            if (c == CMD_STEP && $urandom_range(7) == 0)
                cmd_backlog[cmd_backlog.size() - 1].from0 = 1'b1;
        end
    endtask

    task automatic run_phase(input int limit, input int n, input int w_ins, input int w_find,
                             input int w_rem, input int w_step, input int span);
        cfg_write(REG_LOAD_LIMIT, {25'($urandom_range(32'h01FF_FFFF)), 7'(limit)});
        cfg_check(REG_LOAD_LIMIT, 32'(limit_val));
        queue_random(n, w_ins, w_find, w_rem, w_step, span);
        wait_drained();
    endtask

    initial begin
        logic [IDX_W-1:0] cluster [4];
        cluster = '{6'd63, 6'd62, 6'd21, 6'd20};
        // Crowd most hashes onto a few home slots, some next to the wrap.
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_key[i]  = $urandom;
            pool_hash[i] = $urandom;
            if (i % 3 != 0)
                pool_hash[i][IDX_W-1:0] = cluster[i % 4];
            if (i % 8 == 7)
                pool_key[i] = pool_key[i - 1];
            if (i % 8 == 5)
                pool_hash[i] = pool_hash[i - 1];
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, wrap of the probe, tombstones, step edges
        push_cmd(CMD_STEP,   32'h0,        32'h0,        6'd0,  1'b1);
        push_cmd(CMD_FIND,   32'h0,        32'h0,        6'd0,  1'b0);
        push_cmd(CMD_REMOVE, 32'h1234_5678, 32'h0,       6'd0,  1'b0);
        push_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1'b1);
        push_cmd(CMD_INSERT, 32'h0,        32'h0000_003F, 6'd0,  1'b0);
        push_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0,  1'b0);
        push_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_007F, 6'd0,  1'b0);
        push_cmd(CMD_FIND,   32'h0,        32'h0000_003F, 6'd0,  1'b0);
        push_cmd(CMD_STEP,   32'h0,        32'h0,        6'd62, 1'b0);
        push_cmd(CMD_STEP,   32'h0,        32'h0,        6'd63, 1'b0);
        push_cmd(CMD_STEP,   32'h0,        32'h0,        6'd63, 1'b1);
        push_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0,  1'b0);
        push_cmd(CMD_FIND,   32'h0,        32'h0000_003F, 6'd0,  1'b0);
        push_cmd(CMD_INSERT, 32'h5,        32'h0000_003F, 6'd0,  1'b0);
        push_cmd(CMD_REMOVE, 32'h0,        32'h0000_003F, 6'd0,  1'b0);
        push_cmd(CMD_REMOVE, 32'h0,        32'h0000_003F, 6'd0,  1'b0);
        push_cmd(CMD_FIND,   32'h0,        32'h0000_003F, 6'd0,  1'b0);
        push_cmd(CMD_FIND,   32'hFFFF_FFFF, 32'h0000_007F, 6'd0,  1'b0);
        push_cmd(CMD_STEP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1'b1);
        wait_drained();

        // an unmapped register must not disturb the load limit
        cfg_write(REG_SPARE, 32'h0);
        cfg_check(REG_LOAD_LIMIT, 32'(LIMIT_RESET));
        cfg_write(REG_LOAD_LIMIT, 32'h0);
        push_cmd(CMD_INSERT, 32'hA5A5_5A5A, 32'h0000_0010, 6'd0, 1'b0);
        push_cmd(CMD_INSERT, 32'h5,        32'h0000_003F, 6'd0, 1'b0);
        push_cmd(CMD_FIND,   32'h5,        32'h0000_003F, 6'd0, 1'b0);
        wait_drained();

        run_phase(1,   100, 30, 30, 25, 15, 32);
        // fill every slot so new keys find no free slot at all
        run_phase(127, 220, 80,  8,  4,  8, POOL_SIZE);
        run_phase(64,  250, 25, 25, 40, 10, POOL_SIZE);
        run_phase(0,    60, 30, 30, 20, 20, 48);
        run_phase(16,  250, 40, 25, 25, 10, 48);
        run_phase(64,  300, 35, 25, 30, 10, 64);
        run_phase($urandom_range(2, 63), 300, 35, 30, 25, 10, 40);

        repeat (2 * SLOTS + 20) @(posedge i_clk);
        if (err_count == 0 && results_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
